>>> sv/vcl_pkg.sv
// Package for the velocity command limiter: widths, register indexes and the
// command word type shared by the pipeline stages and the divider.
// No dependencies.
`default_nettype none

package vcl_pkg;

  // Q4.12 speed and unsigned Q3.12 gain widths
  localparam int SPD_W  = 16;
  localparam int GAIN_W = 15;
  localparam int FRAC_W = 12;

  // Divider: quotient never exceeds the non-negative linear limit (15 bits)
  localparam int Q_W        = 15;
  localparam int DEN_W      = 31;                  // 2^24 + gain * |w| < 2^31
  localparam int REM_W      = Q_W + 24;            // linear limit * 2^24
  localparam int DIV_STAGES = Q_W;                 // one quotient bit per stage
  localparam int TRIAL_W    = DEN_W + Q_W;         // room for shifted divisor + sign

  // Product widths after the Q4.12 rescale
  localparam int PROD_W = 2 * GAIN_W;
  localparam int LIM_W  = PROD_W - FRAC_W;         // 18 bits

  localparam logic [31:0] ONE_Q24 = 32'd16777216;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_FACTOR = 3'd4;

  // Register reset values
  localparam logic [SPD_W-1:0]  RST_MAX_LINEAR  = 16'hF000;   // -1.0
  localparam logic [SPD_W-1:0]  RST_MAX_TURN    = 16'hF000;   // -1.0
  localparam logic [GAIN_W-1:0] RST_TURN_GAIN   = 15'd0;
  localparam logic [GAIN_W-1:0] RST_BACK_FACTOR = 15'd4096;   // 1.0
  localparam logic [GAIN_W-1:0] RST_SIDE_FACTOR = 15'd4096;   // 1.0

  // Command word as it travels down the pipeline
  typedef struct packed {
    logic signed [SPD_W-1:0] fwd;
    logic signed [SPD_W-1:0] turn;
    logic signed [SPD_W-1:0] lat;
    logic                    ok;
  } vcl_cmd_t;

endpackage

`default_nettype wire

>>> sv/vcl_in_if.sv
// Input channel of the velocity command limiter: valid/ready plus command word.
// Depends on vcl_pkg.
`default_nettype none

interface vcl_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [vcl_pkg::SPD_W-1:0] forward_cmd;
  logic signed [vcl_pkg::SPD_W-1:0] turn_cmd;
  logic signed [vcl_pkg::SPD_W-1:0] lateral_cmd;
  logic                             upstream_ok;

  modport source (output valid, forward_cmd, turn_cmd, lateral_cmd, upstream_ok,
                  input ready);
  modport sink   (input valid, forward_cmd, turn_cmd, lateral_cmd, upstream_ok,
                  output ready);
endinterface

`default_nettype wire

>>> sv/vcl_out_if.sv
// Result channel of the velocity command limiter: valid/ready plus limited word.
// Depends on vcl_pkg.
`default_nettype none

interface vcl_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [vcl_pkg::SPD_W-1:0] forward_out;
  logic signed [vcl_pkg::SPD_W-1:0] turn_out;
  logic signed [vcl_pkg::SPD_W-1:0] lateral_out;
  logic                             command_ok;

  modport source (output valid, forward_out, turn_out, lateral_out, command_ok,
                  input ready);
  modport sink   (input valid, forward_out, turn_out, lateral_out, command_ok,
                  output ready);
endinterface

`default_nettype wire

>>> sv/vcl_div.sv
// Pipelined restoring divider: (num * 2^24) / den, one quotient bit per stage,
// with a command word riding alongside. Depends on vcl_pkg.
`default_nettype none

module vcl_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [vcl_pkg::Q_W-1:0]     in_num,
  input  wire logic [vcl_pkg::DEN_W-1:0]   in_den,
  input  wire vcl_pkg::vcl_cmd_t           in_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [vcl_pkg::Q_W-1:0]          out_q,
  output vcl_pkg::vcl_cmd_t                out_tag
);
  import vcl_pkg::*;

  // Stage registers
  logic             v_r   [DIV_STAGES];
  logic [REM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [Q_W-1:0]   q_r   [DIV_STAGES];
  vcl_cmd_t         tag_r [DIV_STAGES];

  // Stage inputs and next values
  logic               rdy      [DIV_STAGES];
  logic               v_in     [DIV_STAGES];
  logic [REM_W-1:0]   rem_in   [DIV_STAGES];
  logic [DEN_W-1:0]   den_in   [DIV_STAGES];
  logic [Q_W-1:0]     q_in     [DIV_STAGES];
  vcl_cmd_t           tag_in   [DIV_STAGES];
  logic [TRIAL_W-1:0] diff     [DIV_STAGES];
  logic [REM_W-1:0]   rem_nxt  [DIV_STAGES];
  logic [Q_W-1:0]     q_nxt    [DIV_STAGES];

  // A stage takes a new word when empty or when the next one moves
  always_comb begin
    for (int j = DIV_STAGES - 1; j >= 0; j--) begin
      if (j == DIV_STAGES - 1) begin
        rdy[j] = !v_r[j] || out_ready;
      end else begin
        rdy[j] = !v_r[j] || rdy[j+1];
      end
    end
  end

  // Route each stage's operands
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (j == 0) begin
        v_in[j]   = in_valid;
        rem_in[j] = {in_num, 24'd0};
        den_in[j] = in_den;
        q_in[j]   = '0;
        tag_in[j] = in_tag;
      end else begin
        v_in[j]   = v_r[j-1];
        rem_in[j] = rem_r[j-1];
        den_in[j] = den_r[j-1];
        q_in[j]   = q_r[j-1];
        tag_in[j] = tag_r[j-1];
      end
    end
  end

  // Trial subtract of the shifted divisor; keep it if it did not go negative
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      diff[j] = TRIAL_W'(rem_in[j]) - (TRIAL_W'(den_in[j]) << (Q_W - 1 - j));
      q_nxt[j] = q_in[j];
      q_nxt[j][Q_W-1-j] = ~diff[j][TRIAL_W-1];
      rem_nxt[j] = diff[j][TRIAL_W-1] ? rem_in[j] : diff[j][REM_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        v_r[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_in[j];
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (rdy[j]) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_in[j];
        q_r[j]   <= q_nxt[j];
        tag_r[j] <= tag_in[j];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_q     = q_r[DIV_STAGES-1];
  assign out_tag   = tag_r[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> sv/velocity_command_limiter_top.sv
// Velocity command limiter top level: config registers, clamp stages and the
// divider pipeline. Depends on vcl_pkg, vcl_in_if, vcl_out_if and vcl_div.
//
// Usage:
//   in_ch  carries one command word (forward, turn, lateral, upstream_ok);
//          a word is taken at a clock edge with valid and ready both high.
//   out_ch returns the limited word in the same order, one per command.
//   cfg_*  writes a limit or gain register at any edge with cfg_we high;
//          write only while no command is in flight. Unknown indexes are
//          dropped.
// Pipeline: input register, multiply stage, 15 divider stages at one quotient
//   bit each, backward-limit multiply, final clamp. One word per cycle
//   sustained while out_ch is ready; the divider pipeline sets the depth.
// Stall: each stage holds while the one after it is full and stalled, so
//   empty stages keep taking words while a result waits on out_ch.
// Reset: synchronous, active low; empties the pipeline and loads the default
//   registers (all limiting off, unit backward and sideways factors).
`default_nettype none

module velocity_command_limiter_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  vcl_in_if.sink                               in_ch,
  vcl_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [vcl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vcl_pkg::SPD_W-1:0]       cfg_data
);
  import vcl_pkg::*;

  // Configuration registers
  logic signed [SPD_W-1:0] mls_r, mtr_r;
  logic [GAIN_W-1:0]       gain_r, bf_r, sf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mls_r  <= RST_MAX_LINEAR;
      mtr_r  <= RST_MAX_TURN;
      gain_r <= RST_TURN_GAIN;
      bf_r   <= RST_BACK_FACTOR;
      sf_r   <= RST_SIDE_FACTOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LINEAR:  mls_r  <= cfg_data;
        CFG_MAX_TURN:    mtr_r  <= cfg_data;
        CFG_TURN_GAIN:   gain_r <= cfg_data[GAIN_W-1:0];
        CFG_BACK_FACTOR: bf_r   <= cfg_data[GAIN_W-1:0];
        CFG_SIDE_FACTOR: sf_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic            lin_off;
  logic [Q_W-1:0]  mls_pos;
  assign lin_off = mls_r[SPD_W-1];
  assign mls_pos = lin_off ? '0 : mls_r[Q_W-1:0];

  // Pipeline registers
  logic              v1_r, v2_r, v3_r, v4_r;
  vcl_cmd_t          c1_r, c2_r, c3_r;
  logic [DEN_W-1:0]  den2_r;
  logic [LIM_W-1:0]  side2_r, low3_r;
  logic [Q_W-1:0]    q3_r;
  logic signed [SPD_W-1:0] fwd4_r, turn4_r, lat4_r;
  logic              ok4_r;

  // Ready chain
  logic rdy1, rdy2, rdy3, rdy4;
  logic div_in_ready, div_out_valid;
  logic [Q_W-1:0] div_q;
  vcl_cmd_t div_tag, div_in_tag;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || div_in_ready;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // Stage 1: angular clamp at the input
  logic signed [SPD_W:0]   t_ext, mtr_ext, mtr_neg;
  logic signed [SPD_W-1:0] turn_c;
  assign t_ext   = {in_ch.turn_cmd[SPD_W-1], in_ch.turn_cmd};
  assign mtr_ext = {mtr_r[SPD_W-1], mtr_r};
  assign mtr_neg = -mtr_ext;

  always_comb begin
    turn_c = in_ch.turn_cmd;
    if (in_ch.upstream_ok && !mtr_r[SPD_W-1]) begin
      if (t_ext > mtr_ext) begin
        turn_c = mtr_r;
      end else if (t_ext < mtr_neg) begin
        turn_c = mtr_neg[SPD_W-1:0];
      end
    end
  end

  // Stage 2: divisor 2^24 + gain*|w| and sideways limit
  logic [SPD_W:0]    mag1;
  logic [31:0]       den_prod, den_sum;
  logic [PROD_W-1:0] side_prod;
  assign mag1 = c1_r.turn[SPD_W-1] ? (17'd0 - {c1_r.turn[SPD_W-1], c1_r.turn})
                                   : {1'b0, c1_r.turn};
  assign den_prod  = {17'd0, gain_r} * {15'd0, mag1};
  assign den_sum   = den_prod + ONE_Q24;
  assign side_prod = sf_r * mls_pos;

  // Lateral clamp ahead of the divider
  logic signed [LIM_W:0] lat_ext, side_p, side_n;
  logic                  lat_en;
  always_comb begin
    lat_ext = {{3{c2_r.lat[SPD_W-1]}}, c2_r.lat};
    side_p  = $signed({1'b0, side2_r});
    side_n  = -side_p;
    lat_en  = c2_r.ok && (!lin_off || sf_r == '0);
    div_in_tag = c2_r;
    if (lat_en) begin
      if (lat_ext > side_p) begin
        div_in_tag.lat = side_p[SPD_W-1:0];
      end else if (lat_ext < side_n) begin
        div_in_tag.lat = side_n[SPD_W-1:0];
      end
    end
  end

  vcl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (div_in_ready),
    .in_num    (mls_pos),
    .in_den    (den2_r),
    .in_tag    (div_in_tag),
    .out_valid (div_out_valid),
    .out_ready (rdy3),
    .out_q     (div_q),
    .out_tag   (div_tag)
  );

  // Stage 3: backward limit = factor * forward limit
  logic [PROD_W-1:0] low_prod;
  assign low_prod = bf_r * div_q;

  // Stage 4: forward clamp into the output register
  logic signed [LIM_W:0]   fwd_ext, q_p, low_n;
  logic signed [SPD_W-1:0] fwd_c;
  always_comb begin
    fwd_ext = {{3{c3_r.fwd[SPD_W-1]}}, c3_r.fwd};
    q_p     = $signed({4'd0, q3_r});
    low_n   = -$signed({1'b0, low3_r});
    fwd_c   = c3_r.fwd;
    if (c3_r.ok && !lin_off) begin
      if (fwd_ext > q_p) begin
        fwd_c = q_p[SPD_W-1:0];
      end else if (fwd_ext < low_n) begin
        fwd_c = low_n[SPD_W-1:0];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= div_out_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      c1_r.fwd  <= in_ch.forward_cmd;
      c1_r.turn <= turn_c;
      c1_r.lat  <= in_ch.lateral_cmd;
      c1_r.ok   <= in_ch.upstream_ok;
    end
    if (rdy2) begin
      c2_r    <= c1_r;
      den2_r  <= den_sum[DEN_W-1:0];
      side2_r <= side_prod[PROD_W-1:FRAC_W];
    end
    if (rdy3) begin
      c3_r   <= div_tag;
      q3_r   <= div_q;
      low3_r <= low_prod[PROD_W-1:FRAC_W];
    end
    if (rdy4) begin
      fwd4_r  <= fwd_c;
      turn4_r <= c3_r.turn;
      lat4_r  <= c3_r.lat;
      ok4_r   <= c3_r.ok;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.forward_out = fwd4_r;
  assign out_ch.turn_out    = turn4_r;
  assign out_ch.lateral_out = lat4_r;
  assign out_ch.command_ok  = ok4_r;

  // Checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !v4_r && !v1_r)
    else $error("pipeline not empty after reset");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
      v1_r && !rdy2 |=> v1_r && $stable(c1_r))
    else $error("stage 1 word lost or changed under stall");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
      v3_r && !rdy4 |=> v3_r && $stable(q3_r) && $stable(low3_r))
    else $error("divider result lost or changed under stall");

endmodule

`default_nettype wire
